// File: design/mcss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_pkg
// Types, codes and constants shared by the servo slew controller modules.
// ----------------------------------------------------------------------------
package mcss_pkg;

    localparam int POS_W    = 10;
    localparam int SPEED_W  = 8;
    localparam int PCT_W    = 7;
    localparam int KIND_W   = 3;
    localparam int CHAN_W   = 5;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_CONFIGURE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_COMMAND   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TICK      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ZERO      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PANIC     = 3'd4;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_ZERO = 7'd20;

    // span * pct fits in 17 bits; dividing by 100 is a multiply by
    // ceil(2^24 / 100) and a shift, exact for every product below 2^17.
    localparam int PROD_W      = 17;
    localparam int RECIP_W     = 18;
    localparam int ACC_W       = PROD_W + RECIP_W;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 18'd167773;

    typedef struct packed {
        logic [POS_W-1:0]   lower;
        logic [POS_W-1:0]   upper;
        logic [POS_W-1:0]   cur;
        logic [POS_W-1:0]   tgt;
        logic [SPEED_W-1:0] speed;
        logic               inverted;
        logic               installed;
        logic               active;
    } chan_rec_t;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic [PCT_W-1:0] pct;
    } rel_req_t;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] value;
    } rel_rsp_t;

    typedef struct packed {
        logic [CHAN_W-1:0] ch;
        logic [POS_W-1:0]  pos;
        logic              off;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_EVAL  = 5'b00100,
        ST_REL   = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        REL_IDLE      = 4'b0001,
        REL_MUL_PCT   = 4'b0010,
        REL_MUL_RECIP = 4'b0100,
        REL_ADD       = 4'b1000
    } rel_state_t;

endpackage

// File: design/mcss_chan_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_chan_mem
// Channel record table: one write port, one registered read port. A record
// that was never written since reset reads as all zero.
// ----------------------------------------------------------------------------
module mcss_chan_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  mcss_pkg::chan_rec_t  wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output mcss_pkg::chan_rec_t  rd_data
);

    mcss_pkg::chan_rec_t mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    mcss_pkg::chan_rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/mcss_relpos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcss_relpos
// Relative position lo + (hi - lo) * pct / 100, worked out on one shared
// multiplier in three steps (span * pct, scale by 1/100, add lo); done pulses for one cycle with the value.
// ----------------------------------------------------------------------------
module mcss_relpos (
    input  logic               aclk,
    input  logic               aresetn,
    input  mcss_pkg::rel_req_t req,
    output mcss_pkg::rel_rsp_t rsp
);

    mcss_pkg::rel_state_t             phase_reg, phase_next;
    logic [mcss_pkg::POS_W-1:0]       span_reg;
    logic [mcss_pkg::POS_W-1:0]       lo_reg;
    logic [mcss_pkg::PCT_W-1:0]       pct_reg;
    logic [mcss_pkg::ACC_W-1:0]       acc_reg;
    logic [mcss_pkg::POS_W-1:0]       value_reg;
    logic                             done_reg, done_next;
    logic [mcss_pkg::PROD_W-1:0]      mul_a;
    logic [mcss_pkg::RECIP_W-1:0]     mul_b;
    logic [mcss_pkg::ACC_W-1:0]       product;

    // The multiplier first forms span * pct, then scales that by 1/100.
    always_comb begin
        if (phase_reg == mcss_pkg::REL_MUL_PCT) begin
            mul_a = mcss_pkg::PROD_W'(span_reg);
            mul_b = mcss_pkg::RECIP_W'(pct_reg);
        end else begin
            mul_a = acc_reg[mcss_pkg::PROD_W-1:0];
            mul_b = mcss_pkg::RECIP_MUL;
        end
        product = mcss_pkg::ACC_W'(mul_a) * mcss_pkg::ACC_W'(mul_b);
    end

    always_comb begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        case (phase_reg)
            mcss_pkg::REL_IDLE: begin
                if (req.start) begin
                    phase_next = mcss_pkg::REL_MUL_PCT;
                end
            end
            mcss_pkg::REL_MUL_PCT:   phase_next = mcss_pkg::REL_MUL_RECIP;
            mcss_pkg::REL_MUL_RECIP: phase_next = mcss_pkg::REL_ADD;
            mcss_pkg::REL_ADD: begin
                phase_next = mcss_pkg::REL_IDLE;
                done_next  = 1'b1;
            end
            default: phase_next = mcss_pkg::REL_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mcss_pkg::REL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (phase_reg == mcss_pkg::REL_IDLE && req.start) begin
            span_reg <= (req.hi >= req.lo) ? req.hi - req.lo : '0;
            lo_reg   <= req.lo;
            pct_reg  <= req.pct;
        end
        if (phase_reg == mcss_pkg::REL_MUL_PCT || phase_reg == mcss_pkg::REL_MUL_RECIP) begin
            acc_reg <= product;
        end
        if (phase_reg == mcss_pkg::REL_ADD) begin
            value_reg <= lo_reg + acc_reg[mcss_pkg::RECIP_SHIFT +: mcss_pkg::POS_W];
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

// File: design/multi_channel_servo_slew_controller.sv
`timescale 1ns / 1ps
// One item at a time; s_ready stays low until it ends. Configure and command
// touch one channel; panic, tick and zero all visit every channel in turn, each
// through a read state and an evaluate state for the table's single read port;
// a tick also waits while m_ready holds a result back. Command and zero all
// also wait on the relative-position unit for each channel.
// Reset (synchronous, aresetn low) clears all channels and sets zero_speed to 1.
// ----------------------------------------------------------------------------
// multi_channel_servo_slew_controller
// Table of servo channels that slew each active channel toward its target
// by its speed on every tick and reports positions or turn-off results.
// ----------------------------------------------------------------------------
module multi_channel_servo_slew_controller #(
    parameter int CHANNELS = 32,
    parameter int STEPS    = 720
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [mcss_pkg::SPEED_W-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mcss_pkg::KIND_W-1:0]   s_kind,
    input  logic [mcss_pkg::CHAN_W-1:0]   s_channel,
    input  logic [mcss_pkg::PCT_W-1:0]    s_position_percent,
    input  logic [mcss_pkg::SPEED_W-1:0]  s_speed,
    input  logic [mcss_pkg::POS_W-1:0]    s_min_pos,
    input  logic [mcss_pkg::POS_W-1:0]    s_max_pos,
    input  logic                          s_inverted,
    input  logic                          s_installed,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mcss_pkg::CHAN_W-1:0]   m_out_channel,
    output logic [mcss_pkg::POS_W-1:0]    m_position,
    output logic                          m_turn_off,
    output logic                          m_last
);

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STEP_MAX = STEPS - 1;
    localparam int CMP_W    = 13;

    mcss_pkg::state_t                state_reg, state_next;
    logic [CH_W-1:0]                 idx_reg, idx_next;
    logic [mcss_pkg::SPEED_W-1:0]    zero_speed_reg;

    logic [mcss_pkg::KIND_W-1:0]     kind_reg;
    logic [mcss_pkg::PCT_W-1:0]      pct_reg;
    logic [mcss_pkg::SPEED_W-1:0]    spd_reg;
    logic [mcss_pkg::POS_W-1:0]      a_reg;
    logic [mcss_pkg::POS_W-1:0]      b_reg;
    logic                            inv_reg;
    logic                            inst_reg;

    logic                            pend_valid_reg, pend_valid_next;
    mcss_pkg::res_t                  pend_reg, pend_next;
    logic                            m_valid_reg, m_valid_next;
    mcss_pkg::res_t                  m_res_reg, m_res_next;
    logic                            m_last_reg, m_last_next;

    mcss_pkg::chan_rec_t             rd;
    mcss_pkg::chan_rec_t             wrec;
    logic                            mem_we;
    logic                            mem_re;
    mcss_pkg::rel_req_t              rel_req;
    mcss_pkg::rel_rsp_t              rel_rsp;

    logic                            accept;
    logic                            in_range;
    logic                            kind_is_scan;
    logic                            out_free;
    logic                            chan_done;

    logic [mcss_pkg::POS_W-1:0]      cfg_lo_raw, cfg_hi_raw, cfg_lo, cfg_hi;
    logic [mcss_pkg::PCT_W-1:0]      pct_sat, pct_adj;
    logic                            tk_up, tk_off;
    logic [mcss_pkg::POS_W-1:0]      tk_base, tk_new;
    logic [mcss_pkg::POS_W:0]        tk_sum;
    mcss_pkg::res_t                  tk_res;

    assign s_ready  = (state_reg == mcss_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_range = (CMP_W'(s_channel) < CMP_W'(CHANNELS));
    assign out_free = !m_valid_reg || m_ready;
    assign kind_is_scan = (kind_reg == mcss_pkg::KIND_TICK) ||
                          (kind_reg == mcss_pkg::KIND_ZERO) ||
                          (kind_reg == mcss_pkg::KIND_PANIC);

    // Limits are ordered first, then each is clamped to the top step.
    assign cfg_lo_raw = (a_reg > b_reg) ? b_reg : a_reg;
    assign cfg_hi_raw = (a_reg > b_reg) ? a_reg : b_reg;
    assign cfg_lo = (CMP_W'(cfg_lo_raw) > CMP_W'(STEP_MAX)) ?
                    mcss_pkg::POS_W'(STEP_MAX) : cfg_lo_raw;
    assign cfg_hi = (CMP_W'(cfg_hi_raw) > CMP_W'(STEP_MAX)) ?
                    mcss_pkg::POS_W'(STEP_MAX) : cfg_hi_raw;

    assign pct_sat = (pct_reg > mcss_pkg::PCT_FULL) ? mcss_pkg::PCT_FULL : pct_reg;
    assign pct_adj = rd.inverted ? mcss_pkg::PCT_FULL - pct_sat : pct_sat;

    // One adder serves both directions: moving up it forms cur + speed,
    // moving down tgt + speed, which is the overshoot test for cur - speed.
    assign tk_up   = rd.cur < rd.tgt;
    assign tk_base = tk_up ? rd.cur : rd.tgt;
    assign tk_sum  = {1'b0, tk_base} + (mcss_pkg::POS_W + 1)'(rd.speed);
    assign tk_off  = !rd.installed || (rd.cur == rd.tgt);
    always_comb begin
        if (tk_up) begin
            tk_new = (tk_sum > {1'b0, rd.tgt}) ? rd.tgt : tk_sum[mcss_pkg::POS_W-1:0];
        end else begin
            tk_new = ({1'b0, rd.cur} < tk_sum) ? rd.tgt :
                     rd.cur - mcss_pkg::POS_W'(rd.speed);
        end
        tk_res.ch  = mcss_pkg::CHAN_W'(idx_reg);
        tk_res.pos = tk_off ? '0 : tk_new;
        tk_res.off = tk_off;
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_res_next      = m_res_reg;
        m_last_next     = m_last_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        wrec            = rd;
        rel_req.start   = 1'b0;
        rel_req.lo      = rd.lower;
        rel_req.hi      = rd.upper;
        rel_req.pct     = pct_adj;
        chan_done       = 1'b0;

        case (state_reg)
            mcss_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        mcss_pkg::KIND_CONFIGURE, mcss_pkg::KIND_COMMAND: begin
                            if (in_range) begin
                                idx_next   = CH_W'(s_channel);
                                state_next = mcss_pkg::ST_READ;
                            end
                        end
                        mcss_pkg::KIND_TICK, mcss_pkg::KIND_ZERO,
                        mcss_pkg::KIND_PANIC: begin
                            idx_next   = '0;
                            state_next = mcss_pkg::ST_READ;
                        end
                        default: state_next = mcss_pkg::ST_IDLE;
                    endcase
                end
            end
            mcss_pkg::ST_READ: begin
                mem_re     = 1'b1;
                state_next = mcss_pkg::ST_EVAL;
            end
            mcss_pkg::ST_EVAL: begin
                case (kind_reg)
                    mcss_pkg::KIND_CONFIGURE: begin
                        wrec.lower     = cfg_lo;
                        wrec.upper     = cfg_hi;
                        wrec.inverted  = inv_reg;
                        wrec.installed = inst_reg;
                        wrec.tgt       = inv_reg ? cfg_hi : cfg_lo;
                        wrec.active    = 1'b0;
                        mem_we         = 1'b1;
                        chan_done      = 1'b1;
                    end
                    mcss_pkg::KIND_COMMAND: begin
                        rel_req.start = 1'b1;
                        state_next    = mcss_pkg::ST_REL;
                    end
                    mcss_pkg::KIND_ZERO: begin
                        rel_req.start = 1'b1;
                        rel_req.pct   = mcss_pkg::PCT_ZERO;
                        state_next    = mcss_pkg::ST_REL;
                    end
                    mcss_pkg::KIND_PANIC: begin
                        wrec.tgt  = rd.cur;
                        mem_we    = 1'b1;
                        chan_done = 1'b1;
                    end
                    mcss_pkg::KIND_TICK: begin
                        if (!rd.active) begin
                            chan_done = 1'b1;
                        end else if (!pend_valid_reg || out_free) begin
                            // The held result goes out once a later one shows
                            // that it is not the last of the tick.
                            if (pend_valid_reg) begin
                                m_valid_next = 1'b1;
                                m_res_next   = pend_reg;
                                m_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_next       = tk_res;
                            if (tk_off) begin
                                wrec.active = 1'b0;
                            end else begin
                                wrec.cur = tk_new;
                            end
                            mem_we    = 1'b1;
                            chan_done = 1'b1;
                        end
                    end
                    default: state_next = mcss_pkg::ST_IDLE;
                endcase
            end
            mcss_pkg::ST_REL: begin
                if (rel_rsp.done) begin
                    if (kind_reg == mcss_pkg::KIND_COMMAND) begin
                        wrec.tgt    = rel_rsp.value;
                        wrec.speed  = spd_reg;
                        wrec.active = 1'b1;
                    end else begin
                        wrec.tgt    = rd.inverted ? rd.upper : rd.lower;
                        wrec.cur    = rel_rsp.value;
                        wrec.speed  = zero_speed_reg;
                        wrec.active = rd.installed;
                    end
                    mem_we    = 1'b1;
                    chan_done = 1'b1;
                end
            end
            mcss_pkg::ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = mcss_pkg::ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_res_next      = pend_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = mcss_pkg::ST_IDLE;
                end
            end
            default: state_next = mcss_pkg::ST_IDLE;
        endcase

        if (chan_done) begin
            if (kind_is_scan && (idx_reg != CH_W'(CHANNELS - 1))) begin
                idx_next   = idx_reg + 1'b1;
                state_next = mcss_pkg::ST_READ;
            end else if (kind_reg == mcss_pkg::KIND_TICK) begin
                state_next = mcss_pkg::ST_FLUSH;
            end else begin
                state_next = mcss_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mcss_pkg::ST_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            zero_speed_reg <= 8'd1;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                zero_speed_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        m_res_reg  <= m_res_next;
        m_last_reg <= m_last_next;
        if (accept) begin
            kind_reg <= s_kind;
            pct_reg  <= s_position_percent;
            spd_reg  <= s_speed;
            a_reg    <= s_min_pos;
            b_reg    <= s_max_pos;
            inv_reg  <= s_inverted;
            inst_reg <= s_installed;
        end
    end

    mcss_chan_mem #(
        .DEPTH (CHANNELS),
        .AW    (CH_W)
    ) u_chan_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_we),
        .wr_addr (idx_reg),
        .wr_data (wrec),
        .rd_en   (mem_re),
        .rd_addr (idx_reg),
        .rd_data (rd)
    );

    mcss_relpos u_relpos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rel_req),
        .rsp     (rel_rsp)
    );

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_res_reg.ch;
    assign m_position    = m_res_reg.pos;
    assign m_turn_off    = m_res_reg.off;
    assign m_last        = m_last_reg;

endmodule
